// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef struct packed {
        logic big;
        logic neg;
    } t_div_flag;

endpackage

// ===== rtl/mi3_div.sv =====
module mi3_div #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int XW         = 4 * mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [XW-1:0]          i_num,
    input  logic [XW-1:0]          i_den,
    input  logic                   i_neg,
    output logic [ELEM_WIDTH-1:0]  o_q,
    output mi3_pkg::t_div_flag     o_flag
);

    localparam int E = ELEM_WIDTH;

    logic [XW-1:0]      r_rem [E+1];
    logic [XW-1:0]      r_den [E+1];
    logic [E-1:0]       r_q   [E+1];
    mi3_pkg::t_div_flag r_flag [E+1];

    // overflow check: quotient would need more than E bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]      <= i_num;
            r_den[0]      <= i_den;
            r_q[0]        <= '0;
            r_flag[0].big <= (i_num >= (i_den << E));
            r_flag[0].neg <= i_neg;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar s = 1; s <= E; s++) begin : g_stage
        localparam int K = E - s;
        logic [XW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = r_den[s-1] << K;
        assign w_ge = (r_rem[s-1] >= w_sh);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (r_rem[s-1] - w_sh) : r_rem[s-1];
                r_den[s]  <= r_den[s-1];
                r_q[s]    <= r_q[s-1] | (w_ge ? (E'(1) << K) : E'(0));
                r_flag[s] <= r_flag[s-1];
            end
        end
    end

    assign o_q    = r_q[E];
    assign o_flag = r_flag[E];

endmodule

// ===== rtl/matrix3_inverse.sv =====
// 3x3 matrix inverse via adjugate, signed fixed point, rounded and saturated.
// Throughput: one matrix per cycle unless the output is stalled; nine divider
// lanes resolve one quotient bit per pipeline stage.
// Reset clears the valid bits only; a held output stalls the whole pipeline.
module matrix3_inverse #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [ELEM_WIDTH-1:0] i_a00,
    input  logic signed [ELEM_WIDTH-1:0] i_a01,
    input  logic signed [ELEM_WIDTH-1:0] i_a02,
    input  logic signed [ELEM_WIDTH-1:0] i_a10,
    input  logic signed [ELEM_WIDTH-1:0] i_a11,
    input  logic signed [ELEM_WIDTH-1:0] i_a12,
    input  logic signed [ELEM_WIDTH-1:0] i_a20,
    input  logic signed [ELEM_WIDTH-1:0] i_a21,
    input  logic signed [ELEM_WIDTH-1:0] i_a22,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ELEM_WIDTH-1:0] o_r00,
    output logic signed [ELEM_WIDTH-1:0] o_r01,
    output logic signed [ELEM_WIDTH-1:0] o_r02,
    output logic signed [ELEM_WIDTH-1:0] o_r10,
    output logic signed [ELEM_WIDTH-1:0] o_r11,
    output logic signed [ELEM_WIDTH-1:0] o_r12,
    output logic signed [ELEM_WIDTH-1:0] o_r20,
    output logic signed [ELEM_WIDTH-1:0] o_r21,
    output logic signed [ELEM_WIDTH-1:0] o_r22,
    output logic                         o_singular,
    output logic                         o_saturated
);

    localparam int E   = ELEM_WIDTH;
    localparam int PW  = 2 * E;
    localparam int CW  = 2 * E + 1;
    localparam int DW  = 3 * E + 3;
    localparam int NS  = 2 * E + 2 * FRAC_BITS + 2;
    localparam int NW  = ((NS > DW) ? NS : DW) + 1;
    localparam int BW  = DW + 1 + E;
    localparam int XW  = ((NW > BW) ? NW : BW) + 1;

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    logic signed [E-1:0] w_a [9];
    assign w_a[0] = i_a00;
    assign w_a[1] = i_a01;
    assign w_a[2] = i_a02;
    assign w_a[3] = i_a10;
    assign w_a[4] = i_a11;
    assign w_a[5] = i_a12;
    assign w_a[6] = i_a20;
    assign w_a[7] = i_a21;
    assign w_a[8] = i_a22;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [E-1:0]  r1_a [9];
    logic signed [PW-1:0] r2_p [9];
    logic signed [PW-1:0] r2_q [9];
    logic signed [E-1:0]  r2_a0 [3];
    logic signed [CW-1:0] r3_cof [9];
    logic signed [E-1:0]  r3_a0 [3];
    logic signed [CW-1:0] r4_lo [3];
    logic signed [CW-1:0] r4_hi [3];
    logic signed [CW-1:0] r4_cof [9];
    logic signed [DW-1:0] r5_det;
    logic signed [CW-1:0] r5_cof [9];
    logic [XW-1:0]        r6_num [9];
    logic                 r6_neg [9];
    logic [XW-1:0]        r6_den;
    logic                 r6_sing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a <= w_a;
        end
    end

    // cofactor (x,y): signed 2x2 minor of rows != x, cols != y
    for (genvar x = 0; x < 3; x++) begin : g_row
        for (genvar y = 0; y < 3; y++) begin : g_col
            localparam int X1 = (x == 0) ? 1 : 0;
            localparam int X2 = (x == 2) ? 1 : 2;
            localparam int Y1 = (y == 0) ? 1 : 0;
            localparam int Y2 = (y == 2) ? 1 : 2;
            localparam int K  = x * 3 + y;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r2_p[K] <= PW'(r1_a[X1*3+Y1]) * PW'(r1_a[X2*3+Y2]);
                    r2_q[K] <= PW'(r1_a[X1*3+Y2]) * PW'(r1_a[X2*3+Y1]);
                    if (((x + y) % 2) == 0) begin
                        r3_cof[K] <= CW'(r2_p[K]) - CW'(r2_q[K]);
                    end else begin
                        r3_cof[K] <= CW'(r2_q[K]) - CW'(r2_p[K]);
                    end
                end
            end
        end
    end

    // det = sum of row 0 times its cofactors, cofactor split in two halves
    for (genvar y = 0; y < 3; y++) begin : g_det
        logic signed [CW-1:0] w_lo;
        logic signed [CW-1:0] w_hi;
        assign w_lo = $signed({{(E+1){1'b0}}, r3_cof[y][E-1:0]});
        assign w_hi = CW'($signed(r3_cof[y][CW-1:E]));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r2_a0[y] <= r1_a[y];
                r3_a0[y] <= r2_a0[y];
                r4_lo[y] <= CW'(r3_a0[y]) * w_lo;
                r4_hi[y] <= CW'(r3_a0[y]) * w_hi;
            end
        end
    end

    logic signed [DW-1:0] w_term [3];
    for (genvar y = 0; y < 3; y++) begin : g_term
        assign w_term[y] = (DW'(r4_hi[y]) <<< E) + DW'(r4_lo[y]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cof <= r3_cof;
            r5_cof <= r4_cof;
            r5_det <= w_term[0] + w_term[1] + w_term[2];
        end
    end

    logic [DW-1:0] w_dmag;
    assign w_dmag = r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);

    // lane (i,j) divides cofactor (j,i) by det
    for (genvar k = 0; k < 9; k++) begin : g_num
        localparam int C = (k % 3) * 3 + (k / 3);
        logic [CW-1:0] w_cm;
        assign w_cm = r5_cof[C][CW-1] ? CW'(-r5_cof[C]) : CW'(r5_cof[C]);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r6_num[k] <= (XW'(w_cm) << (2 * FRAC_BITS + 1)) + XW'(w_dmag);
                r6_neg[k] <= r5_cof[C][CW-1] ^ r5_det[DW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_den  <= XW'(w_dmag) << 1;
            r6_sing <= (r5_det == '0);
        end
    end

    logic [E-1:0]       w_q    [9];
    mi3_pkg::t_div_flag w_flag [9];

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_div #(
            .ELEM_WIDTH (E),
            .XW         (XW)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r6_num[k]),
            .i_den  (r6_den),
            .i_neg  (r6_neg[k]),
            .o_q    (w_q[k]),
            .o_flag (w_flag[k])
        );
    end

    logic r_vd [E+1];
    logic r_sd [E+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= E; s++) begin
                r_vd[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vd[0] <= r_v6;
            for (int s = 1; s <= E; s++) begin
                r_vd[s] <= r_vd[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r6_sing;
            for (int s = 1; s <= E; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // round already done, now clip
    localparam logic [E-1:0] LIM = E'(1) << (E - 1);

    logic [E-1:0] w_val [9];
    logic [8:0]   w_clip;

    for (genvar k = 0; k < 9; k++) begin : g_sat
        logic [E-1:0] w_mag;
        always_comb begin
            w_mag = w_q[k];
            if (w_flag[k].neg) begin
                w_clip[k] = w_flag[k].big || (w_q[k] > LIM);
                if (w_clip[k]) begin
                    w_mag = LIM;
                end
                w_val[k] = E'(~w_mag + E'(1));
            end else begin
                w_clip[k] = w_flag[k].big || (w_q[k] > (LIM - E'(1)));
                if (w_clip[k]) begin
                    w_mag = LIM - E'(1);
                end
                w_val[k] = w_mag;
            end
        end
    end

    logic               r_ov;
    logic signed [E-1:0] r_out [9];
    logic               r_sing;
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_vd[E];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sing <= r_sd[E];
            r_sat  <= !r_sd[E] && (w_clip != '0);
            for (int k = 0; k < 9; k++) begin
                r_out[k] <= r_sd[E] ? '0 : $signed(w_val[k]);
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;
    assign o_r00 = r_out[0];
    assign o_r01 = r_out[1];
    assign o_r02 = r_out[2];
    assign o_r10 = r_out[3];
    assign o_r11 = r_out[4];
    assign o_r12 = r_out[5];
    assign o_r20 = r_out[6];
    assign o_r21 = r_out[7];
    assign o_r22 = r_out[8];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (!o_saturated && o_r00 == '0 && o_r11 == '0
            && o_r22 == '0 && o_r01 == '0 && o_r10 == '0))
        else $error("singular result not cleared");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v6) && $stable(r_vd[E]) && $stable(r_v1)))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== test/tb_matrix3_inverse.sv =====
module tb_matrix3_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = mi3_pkg::ELEM_WIDTH_DEF;
    localparam int FB = mi3_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM = 700;
    localparam int LATENCY = EW + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [3*EW+8:0] t_det;
    typedef logic signed [2*EW+4:0] t_cof;
    typedef logic [4*EW+8:0] t_wide;
    typedef struct {
        t_elem a [9];
    } t_matrix;
    typedef struct {
        t_elem r [9];
        logic  singular;
        logic  saturated;
    } t_inverse;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_singular, o_saturated;
    t_elem in_a [9];
    t_elem out_r [9];

    t_matrix  pending_q [$];
    t_inverse inverse_q [$];
    int mismatches = 0;
    int cycles = 0;
    bit stim_done = 1'b0;
    int hold_off = 0;

    initial for (int k = 0; k < 9; k++) in_a[k] = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    matrix3_inverse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a00(in_a[0]), .i_a01(in_a[1]), .i_a02(in_a[2]),
        .i_a10(in_a[3]), .i_a11(in_a[4]), .i_a12(in_a[5]),
        .i_a20(in_a[6]), .i_a21(in_a[7]), .i_a22(in_a[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_r00(out_r[0]), .o_r01(out_r[1]), .o_r02(out_r[2]),
        .o_r10(out_r[3]), .o_r11(out_r[4]), .o_r12(out_r[5]),
        .o_r20(out_r[6]), .o_r21(out_r[7]), .o_r22(out_r[8]),
        .o_singular(o_singular), .o_saturated(o_saturated)
    );

    function automatic t_inverse invert(t_matrix m);
        t_inverse res;
        t_det det;
        t_cof cof;
        t_wide num, den, q, lim;
        t_det e [3][3];
        logic cneg, dneg;
        int r1, r2, c1, c2;
        for (int k = 0; k < 9; k++) e[k/3][k%3] = t_det'(m.a[k]);
        det = e[0][0]*e[1][1]*e[2][2] + e[0][1]*e[1][2]*e[2][0]
            + e[0][2]*e[1][0]*e[2][1] - e[0][0]*e[1][2]*e[2][1]
            - e[0][1]*e[1][0]*e[2][2] - e[0][2]*e[1][1]*e[2][0];
        dneg = det[3*EW+8];
        res.singular = (det == t_det'(0));
        res.saturated = 1'b0;
        lim = t_wide'(1) << (EW - 1);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                // cofactor of (j,i)
                r1 = (j == 0) ? 1 : 0; r2 = (j == 2) ? 1 : 2;
                c1 = (i == 0) ? 1 : 0; c2 = (i == 2) ? 1 : 2;
                cof = t_cof'(e[r1][c1]*e[r2][c2] - e[r1][c2]*e[r2][c1]);
                if ((i + j) % 2) cof = -cof;
                cneg = cof[2*EW+4];
                if (res.singular) begin
                    res.r[i*3+j] = '0;
                end else begin
                    num = cneg ? t_wide'(-cof) : t_wide'(cof);
                    den = dneg ? t_wide'(-det) : t_wide'(det);
                    num = (num << (2*FB + 1)) + den;
                    q = num / (den << 1);
                    if (cneg != dneg) begin
                        if (q > lim) begin q = lim; res.saturated = 1'b1; end
                        res.r[i*3+j] = -q[EW-1:0];
                    end else begin
                        if (q > lim - t_wide'(1)) begin
                            q = lim - t_wide'(1);
                            res.saturated = 1'b1;
                        end
                        res.r[i*3+j] = q[EW-1:0];
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic t_elem pick_elem();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return t_elem'($signed($urandom_range(0, 8)) - 4) <<< FB;
            2: return {1'b0, {(EW-1){1'b1}}};
            3: return {1'b1, {(EW-1){1'b0}}};
            4: return t_elem'(int'($urandom_range(0, 1 << (FB + 3))) - (1 << (FB + 2)));
            5: return '0;
            default: return t_elem'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic add_diag(t_elem d0, t_elem d1, t_elem d2);
        t_matrix m;
        for (int k = 0; k < 9; k++) m.a[k] = '0;
        m.a[0] = d0; m.a[4] = d1; m.a[8] = d2;
        pending_q.push_back(m);
    endtask

    initial begin
        t_matrix m;
        t_elem one;
        one = 1 << FB;
        add_diag(one, one, one);
        add_diag(one, one, '0);
        add_diag(-one, one <<< 1, one >>> 1);
        add_diag(1, one, one);
        add_diag(1, 1, 1);
        add_diag(-1, 1, 1);
        add_diag({1'b0, {(EW-1){1'b1}}}, one, one);
        add_diag({1'b1, {(EW-1){1'b0}}}, one, one);
        add_diag({1'b1, {(EW-1){1'b0}}}, {1'b1, {(EW-1){1'b0}}},
                 {1'b1, {(EW-1){1'b0}}});
        add_diag({(EW){1'b1}}, {(EW){1'b1}}, {(EW){1'b1}});
        for (int k = 0; k < 9; k++) m.a[k] = {1'b0, {(EW-1){1'b1}}};
        pending_q.push_back(m);
        for (int k = 0; k < 9; k++) m.a[k] = {1'b1, {(EW-1){1'b0}}};
        pending_q.push_back(m);
        for (int k = 0; k < 9; k++) m.a[k] = t_elem'(k + 1) <<< FB;
        pending_q.push_back(m);
        m.a[8] = 10 <<< FB;
        pending_q.push_back(m);
        for (int k = 0; k < 9; k++) m.a[k] = (k % 2) ? {1'b1, {(EW-1){1'b0}}}
                                                     : {1'b0, {(EW-1){1'b1}}};
        pending_q.push_back(m);
        for (int n = 0; n < N_RANDOM; n++) begin
            for (int k = 0; k < 9; k++) m.a[k] = pick_elem();
            // occasionally make rows dependent
            if ($urandom_range(0, 9) == 0)
                for (int k = 0; k < 3; k++) m.a[6+k] = m.a[k];
            pending_q.push_back(m);
        end
        stim_done = 1'b1;
    end

    int send_wait = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            inverse_q.push_back(invert(pending_q.pop_front()));
            send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 4) < 2) send_wait = 0;
            if (send_wait == 0 && pending_q.size() > 0) begin
                for (int k = 0; k < 9; k++) in_a[k] <= pending_q[0].a[k];
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (pending_q.size() > 0) begin
                for (int k = 0; k < 9; k++) in_a[k] <= pending_q[0].a[k];
                i_valid <= 1'b1;
            end
        end
    end

    int recv_wait = 0;
    bit long_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            i_stall <= (hold_off > 1);
        end else if (!long_done && inverse_q.size() > 20) begin
            long_done = 1'b1;
            hold_off = 150;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            recv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            i_stall <= (recv_wait > 0);
        end else if (recv_wait > 0) begin
            recv_wait--;
            i_stall <= (recv_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        t_inverse want;
        bit bad;
        if (i_rst_n && o_valid && !i_stall) begin
            if (inverse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word");
            end else begin
                want = inverse_q.pop_front();
                bad = (o_singular !== want.singular) || (o_saturated !== want.saturated);
                for (int k = 0; k < 9; k++) if (out_r[k] !== want.r[k]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: sing %b/%b sat %b/%b", want.singular,
                                 o_singular, want.saturated, o_saturated);
                        for (int k = 0; k < 9; k++)
                            $display("  r%0d%0d exp %h got %h", k / 3, k % 3,
                                     want.r[k], out_r[k]);
                    end
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && pending_q.size() == 0 && !i_valid && inverse_q.size() == 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            if (mismatches == 0) $display("[ OK ] regression clean");
            else $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/mi3_pkg.sv
rtl/mi3_div.sv
rtl/matrix3_inverse.sv
test/tb_matrix3_inverse.sv
